// ===== rtl/utf8v_pkg.sv =====
// utf8v_pkg: beat types, byte classes and error codes of the validating utf-8 decoder
package utf8v_pkg;

	// error codes carried on a result beat
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_START = 3'd1;
	localparam logic [2:0] ERR_TRUNCATED = 3'd2;
	localparam logic [2:0] ERR_OVERLONG  = 3'd3;
	localparam logic [2:0] ERR_SURROGATE = 3'd4;
	localparam logic [2:0] ERR_RANGE     = 3'd5;
	localparam logic [2:0] ERR_BAD_CONT  = 3'd6;

	// sequence widths given by a start byte
	localparam logic [2:0] WID_INVALID = 3'd0;
	localparam logic [2:0] WID_ONE     = 3'd1;
	localparam logic [2:0] WID_TWO     = 3'd2;
	localparam logic [2:0] WID_THREE   = 3'd3;
	localparam logic [2:0] WID_FOUR    = 3'd4;

	// lead bytes with special second-byte rules, and byte limits for the range checks
	localparam logic [7:0] LEAD_SURR  = 8'hED;
	localparam logic [7:0] LEAD_TOP   = 8'hF4;
	localparam logic [7:0] CONT_LIMIT = 8'h90;
	localparam logic [7:0] LEAD_LIMIT = 8'hF5;

	// input beat
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} item_t;

	// result beat
	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  error_code;
		logic        last;
	} result_t;

	// classified byte, as queued between front and back
	typedef struct packed {
		logic [7:0] in_byte;
		logic       eos;
		logic [2:0] width;
		logic       bad_cont;
		logic [2:0] lead_err;
		logic [6:0] lead_bits;
	} cls_t;

endpackage

// ===== rtl/utf8v_fifo.sv =====
// utf8v_fifo: small register queue with push/full and pop/empty sides
module utf8v_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// storage, no reset needed on payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/utf8v_classify.sv =====
// utf8v_classify: front-end byte classification ahead of the queue
module utf8v_classify (
	input  utf8v_pkg::item_t item,
	output utf8v_pkg::cls_t  cls
);

	logic [7:0] b;

	assign b = item.in_byte;

	always_comb begin
		cls           = '0;
		cls.in_byte   = b;
		cls.eos       = item.end_of_string;
		cls.bad_cont  = (b[7:6] != 2'b10);
		cls.width     = utf8v_pkg::WID_INVALID;
		cls.lead_err  = utf8v_pkg::ERR_NONE;
		cls.lead_bits = '0;
		// sequence width and lead data bits
		if (!b[7]) begin
			cls.width = utf8v_pkg::WID_ONE;
		end else if (b[7:5] == 3'b110) begin
			cls.width     = utf8v_pkg::WID_TWO;
			cls.lead_bits = {2'b00, b[4:0]};
			// c0 and c1 can only encode overlong forms
			if (b[4:1] == 4'b0000) begin
				cls.lead_err = utf8v_pkg::ERR_OVERLONG;
			end
		end else if (b[7:4] == 4'b1110) begin
			cls.width     = utf8v_pkg::WID_THREE;
			cls.lead_bits = {3'b000, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			cls.width     = utf8v_pkg::WID_FOUR;
			cls.lead_bits = {4'b0000, b[2:0]};
			// f5 to f7 start sequences above the code space
			if (b >= utf8v_pkg::LEAD_LIMIT) begin
				cls.lead_err = utf8v_pkg::ERR_RANGE;
			end
		end
	end

endmodule

// ===== rtl/utf8v_decode.sv =====
// utf8v_decode: back-end sequence assembly, validation and result generation
module utf8v_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cls_valid,
	input  utf8v_pkg::cls_t    cls,
	output logic               cls_take,
	output logic               res_push,
	output utf8v_pkg::result_t res,
	input  logic               res_full
);

	logic [20:0] partial_q;
	logic [1:0]  left_q;
	logic [2:0]  len_q;
	logic [7:0]  lead_q;
	logic [2:0]  perr_q;
	logic        drop_q;

	logic [20:0] partial_n;
	logic [1:0]  left_n;
	logic [2:0]  len_n;
	logic [7:0]  lead_n;
	logic [2:0]  perr_n;
	logic        drop_n;
	logic        res_valid;
	logic [2:0]  pe;
	logic [20:0] pv;
	logic [1:0]  left_dec;
	logic        second;
	logic [7:0]  b;

	assign b        = cls.in_byte;
	assign cls_take = cls_valid && !res_full;
	assign res_push = cls_take && res_valid;

	// next state and result for the byte at the head of the queue
	always_comb begin
		partial_n = partial_q;
		left_n    = left_q;
		len_n     = len_q;
		lead_n    = lead_q;
		perr_n    = perr_q;
		drop_n    = drop_q;
		res_valid = 1'b0;
		res       = '0;
		pe        = perr_q;
		pv        = {partial_q[14:0], b[5:0]};
		left_dec  = left_q - 1'b1;
		second    = ((len_q - {1'b0, left_q}) == 3'd1);
		if (drop_q) begin
			// discard until end of string
			if (cls.eos) begin
				drop_n = 1'b0;
			end
		end else if (left_q == 2'd0) begin
			// start position
			if (cls.width == utf8v_pkg::WID_INVALID) begin
				res_valid      = 1'b1;
				res.error_code = utf8v_pkg::ERR_BAD_START;
				res.last       = 1'b1;
				drop_n         = !cls.eos;
				partial_n      = '0;
				len_n          = '0;
				lead_n         = '0;
				perr_n         = utf8v_pkg::ERR_NONE;
			end else if (cls.width == utf8v_pkg::WID_ONE) begin
				res_valid      = 1'b1;
				res.code_point = {13'd0, b};
				res.last       = cls.eos;
				partial_n      = '0;
				len_n          = '0;
				lead_n         = '0;
				perr_n         = utf8v_pkg::ERR_NONE;
			end else if (cls.eos) begin
				res_valid      = 1'b1;
				res.error_code = utf8v_pkg::ERR_TRUNCATED;
				res.last       = 1'b1;
				partial_n      = '0;
				len_n          = '0;
				lead_n         = '0;
				perr_n         = utf8v_pkg::ERR_NONE;
			end else begin
				len_n     = cls.width;
				left_n    = cls.width[1:0] - 1'b1;
				lead_n    = b;
				perr_n    = cls.lead_err;
				partial_n = {14'd0, cls.lead_bits};
			end
		end else begin
			// continuation position: second-byte checks outrank a bad continuation
			if (second && (pe == utf8v_pkg::ERR_NONE)) begin
				if ((len_q == utf8v_pkg::WID_THREE) && (lead_q[3:0] == 4'd0) && !b[5]) begin
					pe = utf8v_pkg::ERR_OVERLONG;
				end else if ((len_q == utf8v_pkg::WID_FOUR) && (lead_q[2:0] == 3'd0)
						&& (b[5:4] == 2'b00)) begin
					pe = utf8v_pkg::ERR_OVERLONG;
				end else if ((lead_q == utf8v_pkg::LEAD_SURR) && b[5]) begin
					pe = utf8v_pkg::ERR_SURROGATE;
				end else if ((lead_q == utf8v_pkg::LEAD_TOP) && (b >= utf8v_pkg::CONT_LIMIT)) begin
					pe = utf8v_pkg::ERR_RANGE;
				end
			end
			if ((pe == utf8v_pkg::ERR_NONE) && cls.bad_cont) begin
				pe = utf8v_pkg::ERR_BAD_CONT;
			end
			if ((left_dec != 2'd0) && !cls.eos) begin
				// more bytes to come
				partial_n = pv;
				left_n    = left_dec;
				perr_n    = pe;
			end else begin
				res_valid = 1'b1;
				partial_n = '0;
				left_n    = '0;
				len_n     = '0;
				lead_n    = '0;
				perr_n    = utf8v_pkg::ERR_NONE;
				if (left_dec != 2'd0) begin
					// string ended mid-sequence
					res.error_code = utf8v_pkg::ERR_TRUNCATED;
					res.last       = 1'b1;
				end else if (pe != utf8v_pkg::ERR_NONE) begin
					res.error_code = pe;
					res.last       = 1'b1;
					drop_n         = !cls.eos;
				end else begin
					res.code_point = pv;
					res.last       = cls.eos;
				end
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			left_q    <= '0;
			len_q     <= '0;
			lead_q    <= '0;
			perr_q    <= utf8v_pkg::ERR_NONE;
			drop_q    <= 1'b0;
		end else if (cls_take) begin
			partial_q <= partial_n;
			left_q    <= left_n;
			len_q     <= len_n;
			lead_q    <= lead_n;
			perr_q    <= perr_n;
			drop_q    <= drop_n;
		end
	end

endmodule

// ===== rtl/utf8_decoder_validating_core.sv =====
// utf8_decoder_validating_core: validating utf-8 decoder, byte queue in, result queue out
//
//   channel  payload            beat taken when     side
//   item     item_t (byte,eos)  push && !full       input
//   result   result_t           pop && !empty       output
//
// one byte beat per cycle sustained while the result side keeps up; a result appears once the
// byte that completes it has passed the byte queue, then the decoder into the result queue.
// the decoder loop updates its state once per byte taken, while the result queue is not full.
// arst_n clears queue counts and decoder state; no clearing pass is needed.
// a stalled result side fills the result queue, then the byte queue, then full rises.
module utf8_decoder_validating_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  utf8v_pkg::item_t   item,
	output logic               full,
	input  logic               pop,
	output utf8v_pkg::result_t result,
	output logic               empty
);

	localparam int CLS_W = $bits(utf8v_pkg::cls_t);
	localparam int RES_W = $bits(utf8v_pkg::result_t);

	utf8v_pkg::cls_t    cls_in;
	utf8v_pkg::cls_t    cls_head;
	utf8v_pkg::result_t res_beat;
	logic               cls_empty;
	logic               cls_take;
	logic               res_push;
	logic               res_full;

	// front: classify the incoming byte
	utf8v_classify u_classify (
		.item (item),
		.cls  (cls_in)
	);

	// queue between front and back
	utf8v_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cls_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (full),
		.pop    (cls_take),
		.rdata  (cls_head),
		.empty  (cls_empty)
	);

	// back: assemble and validate sequences
	utf8v_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (!cls_empty),
		.cls       (cls_head),
		.cls_take  (cls_take),
		.res_push  (res_push),
		.res       (res_beat),
		.res_full  (res_full)
	);

	// result queue toward the consumer
	utf8v_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_beat),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
